FILE: rtl/core/kil_pkg.sv
// ----------------------------------------------------------------------------
// kil_pkg
// shared types and constants of the keyword / identifier lexer
// ----------------------------------------------------------------------------
package kil_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH     = 16;
    localparam int NUM_KW          = 10;
    localparam int KW_SLOTS        = 8;
    localparam int NUM_OPS         = 10;

    localparam logic [3:0] TOK_KEYWORD = 4'd0;
    localparam logic [3:0] TOK_IDENT   = 4'd1;
    localparam logic [3:0] TOK_OP_BASE = 4'd2;

    localparam logic [3:0] WORD_LEN_MAX = 4'd15;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd6
    };

    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        "+", "-", "*", "/", "%", "=", ",", ";", "(", ")"
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       flush;
    } char_word_t;

    typedef struct packed {
        logic [3:0]             token_kind;
        logic                   last;
        logic [FIELD_WIDTH-1:0] keywords_seen;
        logic [FIELD_WIDTH-1:0] identifiers_seen;
        logic [FIELD_WIDTH-1:0] operators_seen;
    } token_word_t;

    typedef struct packed {
        logic        word_vld;
        token_word_t word_tok;
        logic        op_vld;
        token_word_t op_tok;
    } lex_result_t;

endpackage

FILE: rtl/core/keyword_identifier_lexer.sv
// ----------------------------------------------------------------------------
// keyword_identifier_lexer
// byte-stream lexer emitting keyword, identifier and operator tokens
// ----------------------------------------------------------------------------
// usage:
//   char channel: one byte (char_code) or an end-of-stream flush per word,
//   taken when char_valid is high and char_stall is low
//   token channel: token words with kind, last flag and running counts,
//   delivered when token_valid is high and token_stall is low
//   a byte or flush gives zero, one or two tokens (word token, then operator);
//   the first token appears in the cycle after the byte is taken
//   throughput is one byte per cycle while not stalled; a byte with two tokens
//   holds input until the second leaves; the token port moves one word a cycle
//   a new byte is taken in the same cycle the last queued token leaves
//   reset clears the word state and the three totals; no tokens are pending
//   when the receiver stalls, queued tokens hold and char_stall stays high
//   while a queued token is stalled or a second token still waits
// ----------------------------------------------------------------------------
module keyword_identifier_lexer
    import kil_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  char_word_t  char_word,
    output logic        token_valid,
    input  logic        token_stall,
    output token_word_t token_word
);

    logic        accept;
    logic        busy;
    lex_result_t result;

    assign char_stall = busy;
    assign accept     = char_valid && !busy;

    kil_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_word (char_word),
        .result    (result)
    );

    kil_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .result      (result),
        .busy        (busy),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule

FILE: rtl/core/kil_core.sv
// ----------------------------------------------------------------------------
// kil_core
// word state, parallel keyword match, saturating token counters
// ----------------------------------------------------------------------------
module kil_core
    import kil_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  char_word_t  char_word,
    output lex_result_t result
);

    logic [3:0]             word_len_reg;
    logic [3:0]             word_len_next;
    logic [NUM_KW-1:0]      mask_reg;
    logic [NUM_KW-1:0]      mask_next;
    logic [COUNT_WIDTH-1:0] kw_total_reg;
    logic [COUNT_WIDTH-1:0] kw_total_next;
    logic [COUNT_WIDTH-1:0] id_total_reg;
    logic [COUNT_WIDTH-1:0] id_total_next;
    logic [COUNT_WIDTH-1:0] op_total_reg;
    logic [COUNT_WIDTH-1:0] op_total_next;

    logic [7:0]        c;
    logic              alnum;
    logic              is_op;
    logic [3:0]        op_idx;
    logic [NUM_KW-1:0] keep;
    logic [NUM_KW-1:0] len_hit;
    logic              is_kw;
    logic              close_word;
    logic              op_vld;

    assign c     = char_word.char_code;
    assign alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");

    always_comb
    begin
        is_op  = 1'b0;
        op_idx = 4'd0;
        for (int i = NUM_OPS - 1; i >= 0; i--)
        begin
            if (OP_CHARS[i] == c)
            begin
                is_op  = 1'b1;
                op_idx = 4'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_KW; i++)
        begin
            keep[i]    = (word_len_reg < KW_LEN[i]) && (word_len_reg < 4'(KW_SLOTS)) &&
                         (KW_TEXT[i][word_len_reg[2:0]] == c);
            len_hit[i] = (KW_LEN[i] == word_len_reg);
        end
    end

    assign is_kw      = |(mask_reg & len_hit);
    assign close_word = accept && (word_len_reg != 4'd0) && (char_word.flush || !alnum);
    assign op_vld     = accept && !char_word.flush && !alnum && is_op;

    always_comb
    begin
        kw_total_next = kw_total_reg;
        id_total_next = id_total_reg;
        op_total_next = op_total_reg;
        if (close_word && is_kw && !(&kw_total_reg))
        begin
            kw_total_next = kw_total_reg + COUNT_WIDTH'(1);
        end
        if (close_word && !is_kw && !(&id_total_reg))
        begin
            id_total_next = id_total_reg + COUNT_WIDTH'(1);
        end
        if (op_vld && !(&op_total_reg))
        begin
            op_total_next = op_total_reg + COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        word_len_next = word_len_reg;
        mask_next     = mask_reg;
        if (accept)
        begin
            if (char_word.flush || !alnum)
            begin
                word_len_next = 4'd0;
                mask_next     = '1;
            end
            else
            begin
                mask_next = mask_reg & keep;
                if (word_len_reg != WORD_LEN_MAX)
                begin
                    word_len_next = word_len_reg + 4'd1;
                end
            end
        end
    end

    always_comb
    begin
        result.word_vld                  = close_word;
        result.word_tok.token_kind       = is_kw ? TOK_KEYWORD : TOK_IDENT;
        result.word_tok.last             = !op_vld;
        result.word_tok.keywords_seen    = FIELD_WIDTH'(kw_total_next);
        result.word_tok.identifiers_seen = FIELD_WIDTH'(id_total_next);
        result.word_tok.operators_seen   = FIELD_WIDTH'(op_total_reg);
        result.op_vld                    = op_vld;
        result.op_tok.token_kind         = TOK_OP_BASE + op_idx;
        result.op_tok.last               = 1'b1;
        result.op_tok.keywords_seen      = FIELD_WIDTH'(kw_total_next);
        result.op_tok.identifiers_seen   = FIELD_WIDTH'(id_total_next);
        result.op_tok.operators_seen     = FIELD_WIDTH'(op_total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= 4'd0;
            mask_reg     <= '1;
            kw_total_reg <= '0;
            id_total_reg <= '0;
            op_total_reg <= '0;
        end
        else
        begin
            word_len_reg <= word_len_next;
            mask_reg     <= mask_next;
            kw_total_reg <= kw_total_next;
            id_total_reg <= id_total_next;
            op_total_reg <= op_total_next;
        end
    end

    // no pending word means every keyword is still a candidate
    a_idle_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (word_len_reg == 4'd0) |-> (mask_reg == '1))
        else $error("match mask narrowed without a pending word");

    a_kw_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (close_word && is_kw) |-> (mask_reg != '0))
        else $error("keyword emitted with empty match mask");

    a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (kw_total_reg >= $past(kw_total_reg)) &&
                 (id_total_reg >= $past(id_total_reg)) &&
                 (op_total_reg >= $past(op_total_reg)))
        else $error("token total went backwards");

endmodule

FILE: rtl/core/kil_out_buf.sv
// ----------------------------------------------------------------------------
// kil_out_buf
// two-entry result register holding the word token and the operator token
// ----------------------------------------------------------------------------
module kil_out_buf
    import kil_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  lex_result_t result,
    output logic        busy,
    output logic        token_valid,
    input  logic        token_stall,
    output token_word_t token_word
);

    logic        vld0_reg;
    logic        vld0_next;
    logic        vld1_reg;
    logic        vld1_next;
    token_word_t res0_reg;
    token_word_t res0_next;
    token_word_t res1_reg;
    token_word_t res1_next;
    logic        pop;

    assign pop         = vld0_reg && !token_stall;
    assign busy        = vld1_reg || (vld0_reg && token_stall);
    assign token_valid = vld0_reg;
    assign token_word  = res0_reg;

    always_comb
    begin
        vld0_next = vld0_reg;
        vld1_next = vld1_reg;
        res0_next = res0_reg;
        res1_next = res1_reg;
        if (pop)
        begin
            vld0_next = vld1_reg;
            res0_next = res1_reg;
            vld1_next = 1'b0;
        end
        if (load && (result.word_vld || result.op_vld))
        begin
            vld0_next = 1'b1;
            vld1_next = result.word_vld && result.op_vld;
            res0_next = result.word_vld ? result.word_tok : result.op_tok;
            res1_next = result.op_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= vld0_next;
            vld1_reg <= vld1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld1_reg |-> vld0_reg)
        else $error("second slot full with first slot empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!vld1_reg && (!vld0_reg || pop)))
        else $error("results loaded over an undelivered word");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vld0_reg |-> (res0_reg.last == !vld1_reg))
        else $error("last flag does not match queued results");

endmodule
